@@ hdl/lpr_pkg.sv @@
`default_nettype none

package lpr_pkg;

  // Largest field count that a request may announce.
  localparam int unsigned MaxCount = 4096;

  // Header words are four bytes, least significant byte first.
  localparam int unsigned HdrBytes = 4;

  // Widths of the working state.
  localparam int unsigned FieldsW  = $clog2(MaxCount + 1);
  localparam int unsigned PayloadW = 32;
  localparam int unsigned FieldNumW = 12;

  // Packed output tdata: payload_byte, field_number, field_end, request_error.
  localparam int unsigned OutDataW = 24;

  typedef enum logic [2:0] {
    PhCount   = 3'd0,
    PhLen     = 3'd1,
    PhPayload = 3'd2,
    PhDone    = 3'd3,
    PhError   = 3'd4
  } phase_e;

endpackage

`default_nettype wire

@@ hdl/length_prefixed_request_parser.sv @@
// A result item is registered; it is output in the cycle after its input item is accepted.
// One input item per cycle unless the output stalls, with a single result register.
// An input item is taken while the result register is empty or being drained in the same cycle.
// Input items that produce no result (header bytes, ignored bytes) leave the output untouched.
// Reset (rst_ni low, asynchronous) returns the parser to the count header and empties the output.
`default_nettype none

module length_prefixed_request_parser (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  wire         s_axis_tlast,   // end_of_request
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // [7:0] payload_byte, [19:8] field_number, [20] field_end, [21] request_error, [23:22] zero
  output logic [lpr_pkg::OutDataW-1:0] m_axis_tdata,
  output logic        m_axis_tuser,   // payload_valid
  output logic        m_axis_tlast    // request_done
);

  // Parser state.
  lpr_pkg::phase_e                    phase_q, phase_d;
  logic [1:0]                         hdr_idx_q, hdr_idx_d;
  logic [23:0]                        hdr_shift_q, hdr_shift_d;
  logic [lpr_pkg::FieldsW-1:0]        fields_rem_q, fields_rem_d;
  logic [lpr_pkg::PayloadW-1:0]       pay_rem_q, pay_rem_d;
  logic [lpr_pkg::FieldNumW-1:0]      cur_field_q, cur_field_d;
  logic                               err_seen_q, err_seen_d;

  // Result register.
  logic                               out_valid_q;
  logic                               out_pvalid_q, out_pvalid_d;
  logic [7:0]                         out_byte_q, out_byte_d;
  logic [lpr_pkg::FieldNumW-1:0]      out_fnum_q, out_fnum_d;
  logic                               out_fend_q, out_fend_d;
  logic                               out_done_q, out_done_d;
  logic                               out_err_q, out_err_d;

  logic                               in_fire;
  logic                               emit;
  logic [31:0]                        hdr_word;
  logic                               hdr_full;

  // The result register can take a new item when it is empty or drains now.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Header assembly: the fourth byte completes the little-endian word.
  assign hdr_full = (hdr_idx_q == 2'(lpr_pkg::HdrBytes - 1));
  assign hdr_word = {s_axis_tdata, hdr_shift_q};

  // One parse step per accepted item.
  always_comb begin
    phase_d      = phase_q;
    hdr_idx_d    = hdr_idx_q;
    hdr_shift_d  = hdr_shift_q;
    fields_rem_d = fields_rem_q;
    pay_rem_d    = pay_rem_q;
    cur_field_d  = cur_field_q;
    err_seen_d   = err_seen_q;
    out_pvalid_d = 1'b0;
    out_byte_d   = 8'd0;
    out_fnum_d   = '0;
    out_fend_d   = 1'b0;
    out_done_d   = 1'b0;
    out_err_d    = 1'b0;

    if (in_fire) begin
      // Shift header bytes in while a header is being read.
      if (phase_q == lpr_pkg::PhCount || phase_q == lpr_pkg::PhLen) begin
        if (hdr_full) begin
          hdr_idx_d   = 2'd0;
          hdr_shift_d = '0;
        end else begin
          hdr_idx_d = hdr_idx_q + 2'd1;
          case (hdr_idx_q)
            2'd0:    hdr_shift_d[7:0]   = s_axis_tdata;
            2'd1:    hdr_shift_d[15:8]  = s_axis_tdata;
            2'd2:    hdr_shift_d[23:16] = s_axis_tdata;
            default: hdr_shift_d        = hdr_shift_q;
          endcase
        end
      end

      case (phase_q)
        lpr_pkg::PhCount: begin
          if (hdr_full) begin
            if (hdr_word > 32'(lpr_pkg::MaxCount)) begin
              err_seen_d = 1'b1;
              phase_d    = lpr_pkg::PhError;
            end else if (hdr_word == 32'd0) begin
              phase_d = lpr_pkg::PhDone;
            end else begin
              fields_rem_d = hdr_word[lpr_pkg::FieldsW-1:0];
              phase_d      = lpr_pkg::PhLen;
            end
          end
        end
        lpr_pkg::PhLen: begin
          if (hdr_full) begin
            if (hdr_word == 32'd0) begin
              // Empty field: an end marker with no data.
              out_fnum_d   = cur_field_q;
              out_fend_d   = 1'b1;
              cur_field_d  = cur_field_q + 1'b1;
              fields_rem_d = fields_rem_q - 1'b1;
              phase_d      = (fields_rem_q != lpr_pkg::FieldsW'(1)) ?
                             lpr_pkg::PhLen : lpr_pkg::PhDone;
            end else begin
              pay_rem_d = hdr_word;
              phase_d   = lpr_pkg::PhPayload;
            end
          end
        end
        lpr_pkg::PhPayload: begin
          out_pvalid_d = 1'b1;
          out_byte_d   = s_axis_tdata;
          out_fnum_d   = cur_field_q;
          pay_rem_d    = pay_rem_q - 1'b1;
          if (pay_rem_q == lpr_pkg::PayloadW'(1)) begin
            out_fend_d   = 1'b1;
            cur_field_d  = cur_field_q + 1'b1;
            fields_rem_d = fields_rem_q - 1'b1;
            phase_d      = (fields_rem_q != lpr_pkg::FieldsW'(1)) ?
                           lpr_pkg::PhLen : lpr_pkg::PhDone;
          end
        end
        lpr_pkg::PhDone: begin
          // Any byte after the last field is trailing data.
          err_seen_d = 1'b1;
          phase_d    = lpr_pkg::PhError;
        end
        default: begin
          phase_d = lpr_pkg::PhError;
        end
      endcase

      // End of request: report and return to the reset state.
      if (s_axis_tlast) begin
        out_done_d   = 1'b1;
        out_err_d    = err_seen_d || (phase_d != lpr_pkg::PhDone);
        phase_d      = lpr_pkg::PhCount;
        hdr_idx_d    = 2'd0;
        hdr_shift_d  = '0;
        fields_rem_d = '0;
        pay_rem_d    = '0;
        cur_field_d  = '0;
        err_seen_d   = 1'b0;
      end
    end
  end

  assign emit = in_fire && (out_pvalid_d || out_fend_d || out_done_d);

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= lpr_pkg::PhCount;
      hdr_idx_q    <= 2'd0;
      hdr_shift_q  <= '0;
      fields_rem_q <= '0;
      pay_rem_q    <= '0;
      cur_field_q  <= '0;
      err_seen_q   <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      hdr_idx_q    <= hdr_idx_d;
      hdr_shift_q  <= hdr_shift_d;
      fields_rem_q <= fields_rem_d;
      pay_rem_q    <= pay_rem_d;
      cur_field_q  <= cur_field_d;
      err_seen_q   <= err_seen_d;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload, loaded only with a new result item.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_pvalid_q <= out_pvalid_d;
      out_byte_q   <= out_byte_d;
      out_fnum_q   <= out_fnum_d;
      out_fend_q   <= out_fend_d;
      out_done_q   <= out_done_d;
      out_err_q    <= out_err_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_err_q, out_fend_q, out_fnum_q, out_byte_q};
  assign m_axis_tuser  = out_pvalid_q;
  assign m_axis_tlast  = out_done_q;

  // A payload phase always has bytes left to read.
  a_pay_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == lpr_pkg::PhPayload) |-> (pay_rem_q != '0))
    else $error("payload phase with no bytes remaining");

  // Length or payload phases always have at least one field outstanding.
  a_fields_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == lpr_pkg::PhLen || phase_q == lpr_pkg::PhPayload) |-> (fields_rem_q != '0))
    else $error("field phase with no fields remaining");

  // An accepted end-of-request item leaves the parser at the count header.
  a_eor_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && s_axis_tlast) |=>
      (phase_q == lpr_pkg::PhCount && hdr_idx_q == 2'd0 && cur_field_q == '0 && !err_seen_q))
    else $error("parser not reset after end of request");

  // The error flag only travels with the done flag.
  a_err_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_err_q) |-> out_done_q)
    else $error("request error without request done");

  // A data byte without payload_valid is zero.
  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !out_pvalid_q) |-> (out_byte_q == 8'd0))
    else $error("payload byte nonzero without payload valid");

endmodule

`default_nettype wire
